[sv/avm_pkg.sv]
// Shared types, constants and decode functions for the averaging voltmeter display.
package avm_pkg;

	// Control that rides along with each word in the pipeline.
	typedef struct packed {
		logic valid;
		logic tick;
	} avm_stage_t;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [7:0] SEG_DOT    = 8'h80;
	localparam logic [5:0] SCALE_SPAN = 6'd33;
	localparam logic [5:0] BCD_BASE   = 6'd10;

	// Seven-segment glyphs, a..g in bits 0..6, hex letters above 9.
	function automatic logic [7:0] seg_decode(input logic [3:0] nib);
		logic [7:0] seg;
		case (nib)
			4'h0: seg = 8'h3F;
			4'h1: seg = 8'h06;
			4'h2: seg = 8'h5B;
			4'h3: seg = 8'h4F;
			4'h4: seg = 8'h66;
			4'h5: seg = 8'h6D;
			4'h6: seg = 8'h7D;
			4'h7: seg = 8'h07;
			4'h8: seg = 8'h7F;
			4'h9: seg = 8'h6F;
			4'hA: seg = 8'h77;
			4'hB: seg = 8'h7C;
			4'hC: seg = 8'h39;
			4'hD: seg = 8'h5E;
			4'hE: seg = 8'h79;
			4'hF: seg = 8'h71;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

	// Two BCD digits of a value 0..39: tens in the high nibble.
	function automatic logic [7:0] to_bcd(input logic [5:0] v);
		logic [3:0] tens;
		logic [5:0] units;
		if (v >= 3 * BCD_BASE) begin
			tens  = 4'd3;
			units = v - 6'(3 * BCD_BASE);
		end else if (v >= 2 * BCD_BASE) begin
			tens  = 4'd2;
			units = v - 6'(2 * BCD_BASE);
		end else if (v >= BCD_BASE) begin
			tens  = 4'd1;
			units = v - BCD_BASE;
		end else begin
			tens  = 4'd0;
			units = v;
		end
		return {tens, units[3:0]};
	endfunction

endpackage

[sv/avm_acc.sv]
// Sample accumulator and first pipeline stage.
module avm_acc import avm_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = 8,
	parameter int SAMPLE_BITS = 10,
	localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   nxt_free,
	output avm_stage_t             stage_s1,
	output logic [SUM_W-1:0]       total_s1
);

	localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_next;
	logic             is_last;
	logic             accept;
	logic             s1_free;

	assign s1_free  = !stage_s1.valid || nxt_free;
	assign in_ready = s1_free;
	assign accept   = in_valid && in_ready;
	assign sum_next = sum_q + SUM_W'(sample);
	assign is_last  = (count_q == LAST_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			stage_s1 <= '0;
		end else begin
			if (accept && cmd == CMD_SAMPLE) begin
				if (is_last) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_q + 1'b1;
				end
			end
			// only ticks and group-closing samples go further
			if (s1_free) begin
				stage_s1.valid <= accept && (cmd == CMD_TICK || is_last);
				stage_s1.tick  <= (cmd == CMD_TICK);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && accept) begin
			total_s1 <= sum_next;
		end
	end

endmodule

[sv/avm_div.sv]
// Averaging stage: group sum divided by the group size via reciprocal multiply.
module avm_div import avm_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = 8,
	parameter int SAMPLE_BITS = 10,
	localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  avm_stage_t             stage_s1,
	input  logic [SUM_W-1:0]       total_s1,
	output logic                   s1_take,
	input  logic                   nxt_free,
	output avm_stage_t             stage_s2,
	output logic [SAMPLE_BITS-1:0] avg_s2
);

	// floor(x*RECIP >> DIV_SH) == floor(x/N) for all x below 2^SUM_W
	localparam int DIV_CW  = $clog2(SAMPLES_PER_AVERAGE);
	localparam int DIV_SH  = SUM_W + 2 * DIV_CW;
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint RECIP_VAL =
		((64'sd1 <<< DIV_SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

	logic [PROD_W-1:0] prod;
	logic              s2_free;

	assign s2_free = !stage_s2.valid || nxt_free;
	assign s1_take = s2_free;
	assign prod    = PROD_W'(total_s1) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else if (s2_free) begin
			stage_s2 <= stage_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && stage_s1.valid) begin
			avg_s2 <= prod[DIV_SH +: SAMPLE_BITS];
		end
	end

endmodule

[sv/avm_disp.sv]
// Scaling to tenths of a volt, BCD store and multiplexed digit output register.
module avm_disp import avm_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  avm_stage_t             stage_s2,
	input  logic [SAMPLE_BITS-1:0] avg_s2,
	output logic                   s2_take,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             segments,
	output logic                   high_digit_enable,
	output logic                   low_digit_enable
);

	localparam int Y_W = SAMPLE_BITS + 6;
	localparam int R_W = SAMPLE_BITS + 1;
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
	localparam logic [SAMPLE_BITS-1:0] HALF_SCALE = FULL_SCALE >> 1;

	logic [7:0]     bcd_q;
	logic           show_high_q;
	logic           out_free;
	logic           adv;
	logic [Y_W-1:0] scaled;
	logic [5:0]     quo;
	logic [R_W-1:0] rem;
	logic [5:0]     tenths;
	logic [7:0]     seg_pick;

	assign out_free = !out_valid || out_ready;
	assign adv      = stage_s2.valid && (!stage_s2.tick || out_free);
	assign s2_take  = !stage_s2.valid || adv;

	// divide by 2^n-1: quotient from top bits, fold it back into the
	// remainder, one correction since the remainder stays below twice the divisor
	assign scaled = Y_W'(avg_s2) * Y_W'(SCALE_SPAN) + Y_W'(HALF_SCALE);
	assign quo    = scaled[Y_W-1:SAMPLE_BITS];
	assign rem    = R_W'(scaled[SAMPLE_BITS-1:0]) + R_W'(quo);
	assign tenths = quo + ((rem >= R_W'(FULL_SCALE)) ? 6'd1 : 6'd0);

	assign seg_pick = show_high_q ? (seg_decode(bcd_q[7:4]) | SEG_DOT)
	                              : seg_decode(bcd_q[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q       <= '0;
			show_high_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (adv && !stage_s2.tick) begin
				bcd_q <= to_bcd(tenths);
			end
			if (adv && stage_s2.tick) begin
				show_high_q <= !show_high_q;
			end
			if (out_free) begin
				out_valid <= stage_s2.valid && stage_s2.tick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stage_s2.tick) begin
			segments          <= seg_pick;
			high_digit_enable <= show_high_q;
			low_digit_enable  <= !show_high_q;
		end
	end

`ifndef SYNTHESIS
	a_enable_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (high_digit_enable != low_digit_enable))
		else $error("digit enables not exclusive");

	a_dot_on_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (segments[7] == high_digit_enable))
		else $error("decimal point does not follow high digit");

	a_digit_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_s2.valid && stage_s2.tick && out_free)
		|=> (show_high_q != $past(show_high_q)))
		else $error("digit select did not alternate");

	a_bcd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bcd_q[3:0] <= 4'd9) && (bcd_q[7:4] <= 4'd3))
		else $error("stored reading out of range");
`endif

endmodule

[sv/adc_average_voltmeter_display.sv]
// A refresh tick word passes stage 1, stage 2 and the digit output register to out_valid.
// Throughput: one word per cycle while in_ready is high; a sample adds to the sum, no result.
// A group-closing sample takes effect before any later tick: it runs the same stages.
// Stages: accumulate, reciprocal-multiply average, scale + BCD / digit output register.
// Reset: arst_n asynchronous, active low; clears sum, count, reading (0.0), low digit first.
module adc_average_voltmeter_display import avm_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = 8,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input word
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [SAMPLE_BITS-1:0] sample,
	// result word
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             segments,
	output logic                   high_digit_enable,
	output logic                   low_digit_enable
);

	localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE);

	// Stage 1 holds only ticks and the sample that closes a group,
	// carrying the group sum that includes that sample.
	avm_stage_t             stage_s1;
	logic [SUM_W-1:0]       total_s1;
	logic                   s1_take;

	// Stage 2 holds the truncated average for closing samples.
	avm_stage_t             stage_s2;
	logic [SAMPLE_BITS-1:0] avg_s2;
	logic                   s2_take;

	// Each stage moves on when the one after it is empty or emptying, so
	// a waiting display word only stalls words queued behind a tick.
	avm_acc #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sample   (sample),
		.nxt_free (s1_take),
		.stage_s1 (stage_s1),
		.total_s1 (total_s1)
	);

	// Division by the group size is a constant reciprocal multiply, registered.
	avm_div #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s1 (stage_s1),
		.total_s1 (total_s1),
		.s1_take  (s1_take),
		.nxt_free (s2_take),
		.stage_s2 (stage_s2),
		.avg_s2   (avg_s2)
	);

	// Scaling to 0..33 tenths, BCD store, and the alternating digit driver.
	avm_disp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_disp (
		.clk               (clk),
		.arst_n            (arst_n),
		.stage_s2          (stage_s2),
		.avg_s2            (avg_s2),
		.s2_take           (s2_take),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.segments          (segments),
		.high_digit_enable (high_digit_enable),
		.low_digit_enable  (low_digit_enable)
	);

endmodule
